[rtl/core/sm4_pkg.sv]
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared types, constants and round functions of the SM4 cipher core.
// ----------------------------------------------------------------------------
package sm4_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_PREF,
    ST_RUN,
    ST_DONE
  } sm4_state_e;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RoundW    = $clog2(NumRounds);

  localparam word_t FK0 = 32'hA3B1BAC6;
  localparam word_t FK1 = 32'h56AA3350;
  localparam word_t FK2 = 32'h677D9197;
  localparam word_t FK3 = 32'hB27022DC;

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // Byte-wise S-box substitution of one word.
  function automatic word_t tau(input word_t v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // Linear layer of the data rounds.
  function automatic word_t lin_data(input word_t t);
    return t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
             ^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
  endfunction

  // Linear layer of the key schedule.
  function automatic word_t lin_key(input word_t t);
    return t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
  endfunction

  // Round constant: byte j of word i is (4*i+j)*7 modulo 256.
  function automatic word_t ck_word(input logic [RoundW-1:0] i);
    word_t      w;
    logic [7:0] b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = ({1'b0, i, 2'(j)} * 8'd7);
      w = {w[23:0], b};
    end
    return w;
  endfunction

endpackage

[rtl/core/sm4_block_cipher.sv]
// ----------------------------------------------------------------------------
// sm4_block_cipher
// Iterative SM4 core: one round per cycle through a shared round unit that
// serves both the key schedule and the data rounds.
// ----------------------------------------------------------------------------
// Usage. The 128-bit key is written over the APB port as two 64-bit
// registers, key_high at byte address 0 and key_low at byte address 8;
// either write marks the stored round keys stale. A block is offered on the
// input channel (block_high_i, block_low_i, decrypt_i) with in_valid_i and
// is taken in a beat when in_ready_o is high. in_ready_o is high only while
// the core is idle, so one block is in work at a time. The result leaves on
// the output channel in one beat with out_valid_o and out_ready_i.
//
// Round sequence. After its input beat a block goes through a prefetch of the
// first round key, 32 rounds at one round per cycle (set by the single round
// unit and the one read port of the round key RAM), and the load of the
// output register. The core is idle again right after that load and only
// then takes a new block. The first block after reset or after a key write
// first runs the 32-round key expansion through the same round unit.
//
// Reset clears the key registers to zero and marks the round keys stale; the
// round key RAM itself is not cleared. If the receiver stalls, the finished
// result waits in the output register; the next block may still be taken,
// and it holds in its last step until the output register is free.
// ----------------------------------------------------------------------------
module sm4_block_cipher
  import sm4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        decrypt_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);

  sm4_state_e        state_q, state_d;
  logic [RoundW-1:0] cnt_q, cnt_d;
  logic              keys_ready_q, keys_ready_d;
  logic              out_valid_q, out_valid_d;

  logic [63:0]       key_high_q, key_low_q;
  logic [127:0]      blk_q;
  logic              dec_q;
  logic [127:0]      res_q, res_d;
  word_t             x_q [4];
  word_t             x_d [4];

  // Round key RAM: one write port for the key schedule, one registered read.
  word_t             rk_mem [NumRounds];
  word_t             rk_q;
  logic              rk_we;
  logic [RoundW-1:0] rd_idx;
  logic [RoundW-1:0] rd_addr;

  logic              cfg_wr;
  logic              in_beat;
  logic              key_mode;
  word_t             unit_op;
  word_t             unit_t;
  word_t             unit_new;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = paddr[3] ? key_low_q : key_high_q;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign in_beat       = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign result_high_o = res_q[127:64];
  assign result_low_o  = res_q[63:0];

  // Shared round unit. During the key schedule the round constant is mixed
  // in and the key linear layer applies; during data rounds the stored key.
  assign key_mode = (state_q == ST_KEY);
  assign unit_op  = key_mode ? ck_word(cnt_q) : rk_q;
  assign unit_t   = tau(x_q[1] ^ x_q[2] ^ x_q[3] ^ unit_op);
  assign unit_new = x_q[0] ^ (key_mode ? lin_key(unit_t) : lin_data(unit_t));

  assign rk_we = key_mode;

  // Next key to fetch: the first in the prefetch step, then the one after.
  assign rd_idx  = (state_q == ST_RUN) ? cnt_q + RoundW'(1) : '0;
  assign rd_addr = dec_q ? ~rd_idx : rd_idx;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    res_d        = res_q;
    x_d          = x_q;

    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_beat) begin
          if (keys_ready_q) begin
            state_d = ST_PREF;
          end else begin
            state_d = ST_KEY;
            x_d[0]  = key_high_q[63:32] ^ FK0;
            x_d[1]  = key_high_q[31:0]  ^ FK1;
            x_d[2]  = key_low_q[63:32]  ^ FK2;
            x_d[3]  = key_low_q[31:0]   ^ FK3;
          end
        end
      end
      ST_KEY: begin
        x_d   = '{x_q[1], x_q[2], x_q[3], unit_new};
        cnt_d = cnt_q + RoundW'(1);
        if (cnt_q == RoundW'(NumRounds - 1)) begin
          keys_ready_d = 1'b1;
          state_d      = ST_PREF;
        end
      end
      ST_PREF: begin
        x_d     = '{blk_q[127:96], blk_q[95:64], blk_q[63:32], blk_q[31:0]};
        cnt_d   = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        x_d   = '{x_q[1], x_q[2], x_q[3], unit_new};
        cnt_d = cnt_q + RoundW'(1);
        if (cnt_q == RoundW'(NumRounds - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // The final words leave in reverse order.
        if (!out_valid_q || out_ready_i) begin
          res_d       = {x_q[3], x_q[2], x_q[1], x_q[0]};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      keys_ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      key_high_q   <= '0;
      key_low_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
      if (cfg_wr && !paddr[3]) begin
        key_high_q <= pwdata;
      end
      if (cfg_wr && paddr[3]) begin
        key_low_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    res_q <= res_d;
    if (in_beat) begin
      blk_q <= {block_high_i, block_low_i};
      dec_q <= decrypt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      rk_mem[cnt_q] <= unit_new;
    end
    rk_q <= rk_mem[rd_addr];
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the iterative SM4 block cipher core. Keys go in
// over the APB port and are read back; blocks are streamed through the
// valid/ready channels with random gaps and stalls, and every result beat is
// compared against a behavioral SM4 predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;

  // Key register map: both registers are 64 bits wide, so they sit 8 bytes
  // apart on the configuration port.
  typedef enum logic [0:0] {
    KEY_HIGH_REG,
    KEY_LOW_REG
  } key_reg_e;

  // One 128-bit block as it appears on the ports.
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } sm4_block_t;

  // System parameter FK of the key schedule.
  localparam logic [31:0] FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  // The SM4 substitution box, kept here independently of the design.
  localparam logic [7:0] SUBST [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // Published SM4 known-answer pair: the key and the plaintext are the same
  // 128-bit value.
  localparam sm4_block_t KAT_KEY    = {64'h0123456789ABCDEF, 64'hFEDCBA9876543210};
  localparam sm4_block_t KAT_CIPHER = {64'h681EDF34D206965E, 64'h86B3E94F536E4246};

  // Random phases keep starting until this many blocks have been sent, the
  // directed opening included; the last phase may run a little past it.
  localparam int unsigned BlockTarget = 900;
  localparam int unsigned DrainCycles = 80;

  // --------------------------------------------------------------------------
  // Result tracker: mirrors the key registers and the round key table, turns
  // every accepted block into its expected output, and checks result beats
  // in order against those expectations.
  // --------------------------------------------------------------------------
  class sm4_result_tracker;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] sched_rk [32];
    bit          keys_valid;
    sm4_block_t  pending_results [$];
    int unsigned errors;
    int unsigned blocks;
    int unsigned decrypts;
    int unsigned expansions;
    int unsigned key_writes;

    function new();
      key_hi     = '0;
      key_lo     = '0;
      keys_valid = 1'b0;
      errors     = 0;
      blocks     = 0;
      decrypts   = 0;
      expansions = 0;
      key_writes = 0;
    endfunction

    static function logic [31:0] sub_bytes(logic [31:0] v);
      return {SUBST[v[31:24]], SUBST[v[23:16]], SUBST[v[15:8]], SUBST[v[7:0]]};
    endfunction

    static function logic [31:0] rotl(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    // Any key write makes the stored round keys stale.
    function void write_key(key_reg_e idx, logic [63:0] value);
      if (idx == KEY_HIGH_REG) begin
        key_hi = value;
      end else begin
        key_lo = value;
      end
      keys_valid = 1'b0;
      key_writes++;
    endfunction

    function void derive_schedule();
      logic [31:0] k [4];
      logic [31:0] t;
      logic [31:0] ck;
      k[0] = key_hi[63:32] ^ FK[0];
      k[1] = key_hi[31:0] ^ FK[1];
      k[2] = key_lo[63:32] ^ FK[2];
      k[3] = key_lo[31:0] ^ FK[3];
      ck   = '0;
      for (int i = 0; i < 32; i++) begin
        // Round constant byte j of word i is (4*i+j)*7, truncated to a byte.
        for (int j = 0; j < 4; j++) begin
          ck = {ck[23:0], 8'((4 * i + j) * 7)};
        end
        t           = sub_bytes(k[1] ^ k[2] ^ k[3] ^ ck);
        sched_rk[i] = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
        k[0] = k[1];
        k[1] = k[2];
        k[2] = k[3];
        k[3] = sched_rk[i];
      end
      keys_valid = 1'b1;
      expansions++;
    endfunction

    function sm4_block_t run_rounds(sm4_block_t blk, bit dec);
      logic [31:0] x [4];
      logic [31:0] t;
      logic [31:0] fresh;
      x[0] = blk.hi[63:32];
      x[1] = blk.hi[31:0];
      x[2] = blk.lo[63:32];
      x[3] = blk.lo[31:0];
      for (int r = 0; r < 32; r++) begin
        t     = sub_bytes(x[1] ^ x[2] ^ x[3] ^ sched_rk[dec ? 31 - r : r]);
        fresh = x[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
        x[0] = x[1];
        x[1] = x[2];
        x[2] = x[3];
        x[3] = fresh;
      end
      // The last four words leave in reverse order.
      return {x[3], x[2], x[1], x[0]};
    endfunction

    function void note_block(sm4_block_t blk, bit dec);
      if (!keys_valid) begin
        derive_schedule();
      end
      pending_results.push_back(run_rounds(blk, dec));
      blocks++;
      if (dec) begin
        decrypts++;
      end
    endfunction

    function void check_block(logic [63:0] hi, logic [63:0] lo);
      sm4_block_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no block outstanding: result_high %h, result_low %h", hi, lo);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (hi !== want.hi) begin
        $error("result_high mismatch: expected %h, actual %h", want.hi, hi);
        errors++;
      end
      if (lo !== want.lo) begin
        $error("result_low mismatch: expected %h, actual %h", want.lo, lo);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block ports and clocking.
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] block_high_i;
  logic [63:0] block_low_i;
  logic        decrypt_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  sm4_result_tracker tracker;

  // Upper bounds for the per-beat idle draws. Each phase sets them either to
  // 15 or to 0, the latter giving stretches of back-to-back traffic.
  int unsigned send_gap_max;
  int unsigned recv_stall_max;

  sm4_block_cipher DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .block_high_i  (block_high_i),
    .block_low_i   (block_low_i),
    .decrypt_i     (decrypt_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_high_o (result_high_o),
    .result_low_o  (result_low_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the core hangs. Even if every block paid the full key
  // expansion plus the longest gap and stall, a run would stay several times
  // under this.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All drivers change inputs on the falling edge and look
  // at outputs right after the rising edge, so the core always sees stable
  // inputs and the bench always sees the values from before the edge.
  // --------------------------------------------------------------------------

  // Mostly full-range random words, with all-zero and all-one values mixed in
  // so the field extremes keep showing up.
  function automatic logic [63:0] rand_word64();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Writes one key register over APB, then reads it back in a back-to-back
  // transfer. Entered and left on a falling edge.
  task automatic write_key_reg(key_reg_e idx, logic [63:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 4'(8 * int'(idx));
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_key(idx, value);
    @(negedge clk_i);
    // Read-back: psel stays high, the next setup phase starts right away.
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      $error("prdata mismatch on key register %s: expected %h, actual %h",
             idx.name(), value, prdata);
      tracker.errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Offers one block on the input channel and returns on the falling edge
  // after its beat. Valid is left high so that a zero gap gives a true
  // back-to-back beat; it is dropped for a gap, by wait_idle and at the drain.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit dec);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    block_high_i = hi;
    block_low_i  = lo;
    decrypt_i    = dec;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_block({hi, lo}, dec);
    @(negedge clk_i);
  endtask

  // Key registers are only touched when the core has nothing in flight:
  // input idle and every expected result already taken.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall before each beat, then the result is checked
  // on the edge where it is taken.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_block(result_high_o, result_low_o);
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    sm4_result_tracker probe;
    sm4_block_t        got;
    int unsigned       phase_len;
    int unsigned       key_choice;

    tracker        = new();
    send_gap_max   = 15;
    recv_stall_max = 15;

    // Sanity of the predictor itself against the published known-answer pair,
    // in both directions, before anything is driven into the core.
    probe = new();
    probe.write_key(KEY_HIGH_REG, KAT_KEY.hi);
    probe.write_key(KEY_LOW_REG, KAT_KEY.lo);
    probe.note_block(KAT_KEY, 1'b0);
    probe.note_block(KAT_CIPHER, 1'b1);
    got = probe.pending_results.pop_front();
    if (got !== KAT_CIPHER || probe.pending_results.pop_front() !== KAT_KEY) begin
      $error("predictor disagrees with the SM4 known-answer pair: got %h", got);
      tracker.errors++;
    end

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    block_high_i = '0;
    block_low_i  = '0;
    decrypt_i    = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. Blocks before any key write must use the expanded
    // all-zero reset key.
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b1);
    send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);

    // Standard key: the core's own answers are checked through the predictor,
    // and a decrypt of the known ciphertext must give the plaintext back.
    wait_idle();
    write_key_reg(KEY_HIGH_REG, KAT_KEY.hi);
    write_key_reg(KEY_LOW_REG, KAT_KEY.lo);
    send_block(KAT_KEY.hi, KAT_KEY.lo, 1'b0);
    send_block(KAT_CIPHER.hi, KAT_CIPHER.lo, 1'b1);
    send_block(64'hA5A5A5A5A5A5A5A5, 64'h5A5A5A5A5A5A5A5A, 1'b0);
    send_block(64'h5A5A5A5A5A5A5A5A, 64'hA5A5A5A5A5A5A5A5, 1'b1);

    // Key changes between blocks: only one half at a time, so each register
    // on its own must force a fresh expansion.
    wait_idle();
    write_key_reg(KEY_HIGH_REG, '1);
    send_block('1, '0, 1'b0);
    send_block('0, '1, 1'b1);
    wait_idle();
    write_key_reg(KEY_LOW_REG, '1);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);

    // Writing the same value again still marks the round keys stale.
    wait_idle();
    write_key_reg(KEY_LOW_REG, '1);
    send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b1);

    // Back to an explicit all-zero key.
    wait_idle();
    write_key_reg(KEY_HIGH_REG, '0);
    write_key_reg(KEY_LOW_REG, '0);
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b1);

    // Random part: phases of random length, each possibly under a new key
    // (one half or both) and each with its own gap and stall profile.
    while (tracker.blocks < BlockTarget) begin
      wait_idle();
      key_choice = $urandom_range(0, 4);
      if (key_choice == 1 || key_choice >= 3) begin
        write_key_reg(KEY_HIGH_REG, rand_word64());
      end
      if (key_choice >= 2) begin
        write_key_reg(KEY_LOW_REG, rand_word64());
      end
      send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 15;
      recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      phase_len      = $urandom_range(5, 60);
      repeat (phase_len) begin
        send_block(rand_word64(), rand_word64(), 1'($urandom_range(0, 1)));
      end
    end

    // Drain: every expected result must arrive, then a quiet window catches
    // any stray extra beat.
    in_valid_i = 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Streamed %0d blocks (%0d decrypt) through %0d key expansions,",
             tracker.blocks, tracker.decrypts, tracker.expansions);
    $display("with %0d key register writes, each read back over APB.",
             tracker.key_writes);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sm4_block_cipher.f]
rtl/core/sm4_pkg.sv
rtl/core/sm4_block_cipher.sv
tb/sv/tb_top.sv
